>>> sv/mbm_pkg.sv
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared constants and the quarter-wave cosine generator for the multitone
// bpsk modulator.
// ----------------------------------------------------------------------------
package mbm_pkg;

    // register map, index = paddr / 4
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TONE0_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE1_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE2_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TONE3_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LENGTH = 3'd4;

    // register widths and reset values
    localparam int unsigned STEP_W      = 32;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned STEP_REGS   = 4;
    localparam logic [STEP_W-1:0] STEP0_RST = 32'd894784853;
    localparam logic [STEP_W-1:0] STEP1_RST = 32'd1163220309;
    localparam logic [STEP_W-1:0] STEP2_RST = 32'd1342177280;
    localparam logic [STEP_W-1:0] STEP3_RST = 32'd1476395008;
    localparam logic [LEN_W-1:0]  LEN_RST   = 16'd4800;

    // field widths
    localparam int unsigned BITS_W   = 4;
    localparam int unsigned SAMPLE_W = 18;

    // pi/2 in q2.30
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // quarter-wave cosine at angle pi/2 * m / 2^(addr_bits-2), evaluated at
    // elaboration: taylor series in horner form, nine terms, q30
    function automatic longint unsigned quarter_cos(
        input longint unsigned m,
        input int unsigned     addr_bits,
        input int unsigned     amp_bits
    );
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned shift;
        longint unsigned peak;
        longint unsigned v;
        x     = (PI_HALF_Q30 * m) >> (addr_bits - 2);
        x2    = (x * x) >> 30;
        t     = ONE_Q30;
        shift = 64'(30 - (amp_bits - 1));
        peak  = (64'd1 << (amp_bits - 1)) - 64'd1;
        p = ((x2 * t) >> 30) / 240; t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 182; t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 132; t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 90;  t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 56;  t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 30;  t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 12;  t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 2;   t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        // round half up, saturate at full scale
        v = (t + (64'd1 << (shift - 64'd1))) >> shift;
        if (v > peak) begin
            v = peak;
        end
        return v;
    endfunction

endpackage

>>> sv/mbm_if.sv
// ----------------------------------------------------------------------------
// mbm_in_if / mbm_out_if
// Valid/ready channels of the multitone bpsk modulator.
// ----------------------------------------------------------------------------
interface mbm_in_if;
    logic                              valid;
    logic                              ready;
    logic [mbm_pkg::BITS_W-1:0]        tone_bits;

    modport source (output valid, output tone_bits, input ready);
    modport sink   (input valid, input tone_bits, output ready);
endinterface

interface mbm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mbm_pkg::SAMPLE_W-1:0] sample;
    logic                              symbol_end;

    modport source (output valid, output sample, output symbol_end, input ready);
    modport sink   (input valid, input sample, input symbol_end, output ready);
endinterface

>>> sv/multitone_bpsk_modulator_core.sv
// ----------------------------------------------------------------------------
// multitone_bpsk_modulator_core
// Parallel multi-tone bpsk sample generator with apb configuration.
//
// Each input beat on i_in carries the data bits of one output sample, bit j
// giving the sign of tone j. Every tone looks up the cosine of its phase
// accumulator in a quarter-wave table, applies its sign, and the signed terms
// are summed into one sample on o_out; symbol_end flags the last sample of
// every symbol of symbol_length samples. Phases advance by their step after
// each beat.
// The first stage folds the phases into table lookups and the second
// stage sums the terms. One beat is accepted per cycle while i_in.ready
// is high; the phase update is a single add per tone per beat.
// When o_out stalls, the output register and the first stage hold their beats
// and i_in.ready drops once both are full. Reset (synchronous) clears the
// phases and the sample counter, empties the pipeline and restores the step
// and symbol length registers to their defaults. Configure through apb only
// while no beat is in flight.
// ----------------------------------------------------------------------------
module multitone_bpsk_modulator_core #(
    parameter int unsigned TONES           = 4,
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned TABLE_ADDR_BITS = 10,
    parameter int unsigned AMPLITUDE_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mbm_in_if.sink                           i_in,
    mbm_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int unsigned MAG_W   = AMPLITUDE_BITS - 1;
    localparam int unsigned IDX_W   = TABLE_ADDR_BITS - 1;
    localparam int unsigned R_W     = TABLE_ADDR_BITS - 2;
    localparam int unsigned QUARTER = 1 << R_W;
    localparam int unsigned SUM_W   = AMPLITUDE_BITS + $clog2(TONES) + 1;
    localparam int unsigned EXT_W   =
        (SUM_W > mbm_pkg::SAMPLE_W) ? SUM_W : mbm_pkg::SAMPLE_W;

    // quarter-wave cosine table, constant
    logic [MAG_W-1:0] w_qtab [QUARTER+1];

    for (genvar gm = 0; gm <= QUARTER; gm++) begin : g_qtab
        assign w_qtab[gm] = MAG_W'(mbm_pkg::quarter_cos(64'(gm), TABLE_ADDR_BITS,
                                                        AMPLITUDE_BITS));
    end

    // configuration registers
    logic [mbm_pkg::STEP_W-1:0] r_step [mbm_pkg::STEP_REGS];
    logic [mbm_pkg::LEN_W-1:0]  r_len;
    logic [mbm_pkg::CFG_IDX_W-1:0] w_cfg_idx;
    logic                       w_cfg_wr;

    assign w_cfg_idx = paddr[mbm_pkg::CFG_ADDR_W-1:2];
    assign w_cfg_wr  = psel & penable & pwrite;
    assign pready    = 1'b1;

    // apb write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step[0] <= mbm_pkg::STEP0_RST;
            r_step[1] <= mbm_pkg::STEP1_RST;
            r_step[2] <= mbm_pkg::STEP2_RST;
            r_step[3] <= mbm_pkg::STEP3_RST;
            r_len     <= mbm_pkg::LEN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                mbm_pkg::REG_TONE0_STEP: r_step[0] <= pwdata;
                mbm_pkg::REG_TONE1_STEP: r_step[1] <= pwdata;
                mbm_pkg::REG_TONE2_STEP: r_step[2] <= pwdata;
                mbm_pkg::REG_TONE3_STEP: r_step[3] <= pwdata;
                mbm_pkg::REG_SYMBOL_LENGTH: r_len <= pwdata[mbm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // apb read
    always_comb begin
        unique case (w_cfg_idx)
            mbm_pkg::REG_TONE0_STEP:    prdata = r_step[0];
            mbm_pkg::REG_TONE1_STEP:    prdata = r_step[1];
            mbm_pkg::REG_TONE2_STEP:    prdata = r_step[2];
            mbm_pkg::REG_TONE3_STEP:    prdata = r_step[3];
            mbm_pkg::REG_SYMBOL_LENGTH: prdata = 32'(r_len);
            default:                    prdata = '0;
        endcase
    end

    // pipeline handshake
    logic r_s1_valid;
    logic r_o_valid;
    logic w_adv2;
    logic w_in_fire;

    assign w_adv2      = r_s1_valid & (~r_o_valid | o_out.ready);
    assign i_in.ready  = ~r_s1_valid | ~r_o_valid | o_out.ready;
    assign w_in_fire   = i_in.valid & i_in.ready;

    // phase fold and table lookup per tone
    logic [PHASE_BITS-1:0] r_phase [TONES];
    logic [MAG_W-1:0]      w_mag   [TONES];
    logic [TONES-1:0]      w_pos;

    always_comb begin
        logic [TABLE_ADDR_BITS-1:0] addr;
        logic [1:0]                 quad;
        logic [R_W-1:0]             rem;
        logic [IDX_W-1:0]           idx;
        logic                       bit_j;
        for (int j = 0; j < TONES; j++) begin
            addr  = r_phase[j][PHASE_BITS-1 -: TABLE_ADDR_BITS];
            quad  = addr[TABLE_ADDR_BITS-1 -: 2];
            rem   = addr[R_W-1:0];
            idx   = quad[0] ? (IDX_W'(QUARTER) - IDX_W'(rem)) : IDX_W'(rem);
            bit_j = (j < mbm_pkg::BITS_W) ? i_in.tone_bits[j % mbm_pkg::BITS_W] : 1'b0;
            w_mag[j] = w_qtab[idx];
            // second and third quadrants are negative
            w_pos[j] = bit_j ^ (quad[1] ^ quad[0]);
        end
    end

    // symbol counter
    logic [mbm_pkg::LEN_W-1:0] r_cnt;
    logic [mbm_pkg::LEN_W-1:0] w_len;
    logic [mbm_pkg::LEN_W:0]   w_cnt_inc;
    logic                      w_end;

    assign w_len     = (r_len == '0) ? mbm_pkg::LEN_W'(1) : r_len;
    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_end     = w_cnt_inc >= {1'b0, w_len};

    // stage 1: state update and lookup registers
    logic [MAG_W-1:0] r_s1_mag [TONES];
    logic [TONES-1:0] r_s1_pos;
    logic             r_s1_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt      <= '0;
            for (int j = 0; j < TONES; j++) begin
                r_phase[j] <= '0;
            end
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
                r_cnt      <= w_end ? '0 : w_cnt_inc[mbm_pkg::LEN_W-1:0];
                for (int j = 0; j < TONES; j++) begin
                    if (j < mbm_pkg::STEP_REGS) begin
                        r_phase[j] <= r_phase[j] +
                            PHASE_BITS'(r_step[j % mbm_pkg::STEP_REGS]);
                    end
                end
            end else if (w_adv2) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_mag <= w_mag;
            r_s1_pos <= w_pos;
            r_s1_end <= w_end;
        end
    end

    // stage 2: signed sum of the terms
    logic signed [SUM_W-1:0] w_sum;
    logic signed [EXT_W-1:0] w_ext;

    always_comb begin
        logic signed [SUM_W-1:0] term;
        w_sum = '0;
        for (int j = 0; j < TONES; j++) begin
            term  = $signed(SUM_W'(r_s1_mag[j]));
            w_sum = w_sum + (r_s1_pos[j] ? term : -term);
        end
    end

    assign w_ext = EXT_W'(w_sum);

    logic signed [mbm_pkg::SAMPLE_W-1:0] r_o_sample;
    logic                                r_o_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv2) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_o_sample <= w_ext[mbm_pkg::SAMPLE_W-1:0];
            r_o_end    <= r_s1_end;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.sample     = r_o_sample;
    assign o_out.symbol_end = r_o_end;

    // symbol end in stage 1 goes with a restarted counter
    a_end_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_s1_end == (r_cnt == '0)))
        else $error("symbol end and sample counter disagree");

    // phases only move on an accepted beat
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_fire |=> $stable(r_phase[0]))
        else $error("phase advanced without an input beat");

    // stage 1 keeps its beat while the output side is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv2) |=> (r_s1_valid && $stable(r_s1_end)
                                     && $stable(r_s1_pos)))
        else $error("stage 1 beat lost during stall");

endmodule
